// ===== rtl/ksp_pkg.sv =====
// ----------------------------------------------------------------------------
// ksp_pkg: shared types, constants and microcode for the keyed slot pool
// Holds the pool geometry, field widths, result codes and the control
// program that the sequencer steps through.
// ----------------------------------------------------------------------------
package ksp_pkg;

  // Pool geometry
  localparam int POOL_DEPTH = 64;
  localparam int KEY_BITS   = 32;
  localparam int SLOT_BITS  = $clog2(POOL_DEPTH);
  localparam int COUNT_BITS = $clog2(POOL_DEPTH + 1);

  // Field widths on the ports
  localparam int KEY_FIELD_BITS   = 32;
  localparam int IDX_FIELD_BITS   = 6;
  localparam int FREED_FIELD_BITS = 7;
  localparam int CFG_BITS         = 7;
  localparam int LIM_BITS         = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

  // Configuration port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_MAX_POOL = 1'b0;
  localparam logic [CFG_BITS-1:0] MAX_POOL_RESET = CFG_BITS'(64);

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [KEY_BITS-1:0]   key_t;

  // Result codes
  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_NEW   = 2'd1,
    ST_FULL  = 2'd2,
    ST_PRUNE = 2'd3
  } status_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_MATCH,
    OP_RESOLVE,
    OP_ALLOC,
    OP_POP,
    OP_PINIT,
    OP_PSTEP,
    OP_PDONE
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_PRUNE,
    C_HIT,
    C_DEPTH_ZERO,
    C_WALK_MORE
  } cond_t;

  // Step addresses of the control program
  localparam int STEP_BITS = 4;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_DISPATCH = 4'd1;
  localparam step_t STEP_MATCH    = 4'd2;
  localparam step_t STEP_RESOLVE  = 4'd3;
  localparam step_t STEP_ALLOC    = 4'd4;
  localparam step_t STEP_POP      = 4'd5;
  localparam step_t STEP_PINIT    = 4'd6;
  localparam step_t STEP_PWALK    = 4'd7;
  localparam step_t STEP_PDONE    = 4'd8;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Status flags the sequencer branches on
  typedef struct packed {
    logic start;
    logic prune;
    logic hit;
    logic depth_zero;
    logic walk_more;
  } flags_t;

  // Control store: one word per step
  function automatic ctrl_word_t ucode(step_t s);
    ctrl_word_t w;
    unique case (s)
      STEP_IDLE:     w = '{op: OP_LATCH,   cond: C_IDLE,       target: STEP_IDLE};
      STEP_DISPATCH: w = '{op: OP_NOP,     cond: C_PRUNE,      target: STEP_PINIT};
      STEP_MATCH:    w = '{op: OP_MATCH,   cond: C_NEVER,      target: STEP_IDLE};
      STEP_RESOLVE:  w = '{op: OP_RESOLVE, cond: C_HIT,        target: STEP_IDLE};
      STEP_ALLOC:    w = '{op: OP_ALLOC,   cond: C_DEPTH_ZERO, target: STEP_IDLE};
      STEP_POP:      w = '{op: OP_POP,     cond: C_ALWAYS,     target: STEP_IDLE};
      STEP_PINIT:    w = '{op: OP_PINIT,   cond: C_NEVER,      target: STEP_IDLE};
      STEP_PWALK:    w = '{op: OP_PSTEP,   cond: C_WALK_MORE,  target: STEP_PWALK};
      STEP_PDONE:    w = '{op: OP_PDONE,   cond: C_ALWAYS,     target: STEP_IDLE};
      default:       w = '{op: OP_NOP,     cond: C_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ksp_ram.sv =====
// ----------------------------------------------------------------------------
// ksp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module ksp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ksp_seq.sv =====
// ----------------------------------------------------------------------------
// ksp_seq: microcode sequencer for the keyed slot pool
// Steps a program counter through the control store, taking a jump when
// the control word's condition holds and advancing by one otherwise.
// ----------------------------------------------------------------------------
module ksp_seq (
  input  logic                clk,
  input  logic                rst,
  input  ksp_pkg::flags_t     flags,
  output ksp_pkg::ctrl_word_t ctrl,
  output logic                busy
);

  import ksp_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  taken;

  // Fetch the control word and pick the next step
  always_comb begin
    ctrl = ucode(pc);
    unique case (ctrl.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_IDLE:       taken = !flags.start;
      C_PRUNE:      taken = flags.prune;
      C_HIT:        taken = flags.hit;
      C_DEPTH_ZERO: taken = flags.depth_zero;
      C_WALK_MORE:  taken = flags.walk_more;
      default:      taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : pc + step_t'(1);
  end

  // Hold the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign busy = (pc != STEP_IDLE);

endmodule

// ===== rtl/keyed_slot_pool_with_use_aging.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_pool_with_use_aging: key-to-slot pool with LIFO free list
// Maps keys to numbered slots, recycles slots left unused between prunes.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and tile_key with start high; the word is
//   taken at a clock edge where start is high and busy is low. cmd 0 looks
//   up tile_key, cmd 1 prunes every slot not used since the last prune.
//   Result channel: done pulses for one cycle with status, slot_index and
//   freed_count; the receiver must take it in that cycle.
//   Command steps, set by a microcode sequencer: a fetch passes dispatch,
//   match and resolve, ending there on a hit; a miss goes on to alloc,
//   ending there when the pool is full or a fresh slot is given; reuse
//   from the free list adds a pop step for the registered read of the
//   free-list RAM. A prune inits, walks one slot per cycle, then reports.
//   Configuration: APB register 0 (byte address 0) is max_pool_size,
//   reset 64; write it only while busy is low.
//   Reset clears all mappings, used marks, the free-list depth and the
//   allocation count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_slot_pool_with_use_aging (
  input  logic                                  clk,
  input  logic                                  rst,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  cmd,
  input  logic [ksp_pkg::KEY_FIELD_BITS-1:0]    tile_key,
  // result channel
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [ksp_pkg::IDX_FIELD_BITS-1:0]    slot_index,
  output logic [ksp_pkg::FREED_FIELD_BITS-1:0]  freed_count,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ksp_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [ksp_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [ksp_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                  pready
);

  import ksp_pkg::*;

  ctrl_word_t ctrl;
  flags_t     flags;

  logic [CFG_BITS-1:0]   max_pool_size;
  logic                  cfg_wr;
  count_t                pool_limit;

  key_t                  key_reg;
  logic                  prune_reg;
  key_t                  slot_key [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] mapped;
  logic [POOL_DEPTH-1:0] used;
  logic [POOL_DEPTH-1:0] match_vec;
  count_t                free_depth;
  count_t                alloc_count;
  slot_t                 walk;
  count_t                freed;

  logic                  hit;
  slot_t                 hit_slot;
  logic                  depth_zero;
  logic                  can_fresh;
  slot_t                 fresh_slot;
  logic                  walk_free;

  logic                  ram_we;
  slot_t                 ram_waddr;
  logic                  ram_re;
  slot_t                 ram_raddr;
  slot_t                 ram_rdata;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_BITS-1] == REG_MAX_POOL);
  assign prdata = (paddr[APB_ADDR_BITS-1] == REG_MAX_POOL) ?
                  APB_DATA_BITS'(max_pool_size) : '0;

  // Clamp the limit to the pool size
  always_comb begin
    if (LIM_BITS'(max_pool_size) > LIM_BITS'(POOL_DEPTH)) begin
      pool_limit = count_t'(POOL_DEPTH);
    end else begin
      pool_limit = count_t'(max_pool_size);
    end
  end

  // Encode the matching slot; at most one slot can match a key
  always_comb begin
    hit      = |match_vec;
    hit_slot = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (match_vec[i]) begin
        hit_slot = hit_slot | slot_t'(i);
      end
    end
  end

  assign depth_zero = (free_depth == '0);
  assign can_fresh  = (alloc_count < pool_limit);
  assign fresh_slot = slot_t'(alloc_count);
  assign walk_free  = mapped[walk] && !used[walk];

  assign flags = '{start:      start,
                   prune:      prune_reg,
                   hit:        hit,
                   depth_zero: depth_zero,
                   walk_more:  (walk != slot_t'(POOL_DEPTH - 1))};

  ksp_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Free list: push on prune, pop on a miss with a non-empty list
  assign ram_we    = (ctrl.op == OP_PSTEP) && walk_free &&
                     (free_depth < count_t'(POOL_DEPTH));
  assign ram_waddr = slot_t'(free_depth);
  assign ram_re    = (ctrl.op == OP_ALLOC) && !depth_zero;
  assign ram_raddr = slot_t'(free_depth - count_t'(1));

  ksp_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (POOL_DEPTH)
  ) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (walk),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state: configuration register, mapping flags, counters, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pool_size <= MAX_POOL_RESET;
      mapped        <= '0;
      used          <= '0;
      free_depth    <= '0;
      alloc_count   <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        max_pool_size <= pwdata[CFG_BITS-1:0];
      end
      unique case (ctrl.op)
        OP_RESOLVE: begin
          if (hit) begin
            used[hit_slot] <= 1'b1;
            done           <= 1'b1;
          end
        end
        OP_ALLOC: begin
          if (depth_zero) begin
            done <= 1'b1;
            if (can_fresh) begin
              mapped[fresh_slot] <= 1'b1;
              used[fresh_slot]   <= 1'b1;
              alloc_count        <= alloc_count + count_t'(1);
            end
          end else begin
            free_depth <= free_depth - count_t'(1);
          end
        end
        OP_POP: begin
          mapped[ram_rdata] <= 1'b1;
          used[ram_rdata]   <= 1'b1;
          done              <= 1'b1;
        end
        OP_PSTEP: begin
          if (mapped[walk]) begin
            if (!used[walk]) begin
              mapped[walk] <= 1'b0;
              if (free_depth < count_t'(POOL_DEPTH)) begin
                free_depth <= free_depth + count_t'(1);
              end
            end else begin
              used[walk] <= 1'b0;
            end
          end
        end
        OP_PDONE: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload: latched word, key store, match vector, walk and result fields
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LATCH: begin
        if (start) begin
          key_reg   <= key_t'(tile_key);
          prune_reg <= cmd;
        end
      end
      OP_MATCH: begin
        for (int i = 0; i < POOL_DEPTH; i++) begin
          match_vec[i] <= mapped[i] && (slot_key[i] == key_reg);
        end
      end
      OP_RESOLVE: begin
        if (hit) begin
          status      <= ST_HIT;
          slot_index  <= IDX_FIELD_BITS'(hit_slot);
          freed_count <= '0;
        end
      end
      OP_ALLOC: begin
        if (depth_zero) begin
          freed_count <= '0;
          if (can_fresh) begin
            slot_key[fresh_slot] <= key_reg;
            status               <= ST_NEW;
            slot_index           <= IDX_FIELD_BITS'(fresh_slot);
          end else begin
            status     <= ST_FULL;
            slot_index <= '0;
          end
        end
      end
      OP_POP: begin
        slot_key[ram_rdata] <= key_reg;
        status              <= ST_NEW;
        slot_index          <= IDX_FIELD_BITS'(ram_rdata);
        freed_count         <= '0;
      end
      OP_PINIT: begin
        walk  <= '0;
        freed <= '0;
      end
      OP_PSTEP: begin
        walk <= walk + slot_t'(1);
        if (walk_free) begin
          freed <= freed + count_t'(1);
        end
      end
      OP_PDONE: begin
        status      <= ST_PRUNE;
        slot_index  <= '0;
        freed_count <= FREED_FIELD_BITS'(freed);
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done || $past(rst))
    else $error("command finished without a result");

  a_result_single_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_no_slot_without_mapping: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL || status == ST_PRUNE) |-> slot_index == '0)
    else $error("slot index reported without a mapping");

  a_depth_bounded: assert property (@(posedge clk) disable iff (rst)
    free_depth <= alloc_count)
    else $error("free list deeper than the allocated slot count");

  a_alloc_bounded: assert property (@(posedge clk) disable iff (rst)
    alloc_count <= count_t'(POOL_DEPTH))
    else $error("allocation count beyond pool depth");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking regression for keyed_slot_pool_with_use_aging
// Drives fetch and prune words with random gaps and programs max_pool_size
// over APB between phases. A local pool predictor tracks the key map, the
// used marks, the LIFO free list and the allocation count, and each result
// strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ksp_pkg::*;

  localparam logic CMD_FETCH = 1'b0;
  localparam logic CMD_PRUNE = 1'b1;
  localparam logic [APB_ADDR_BITS-1:0] MAX_POOL_ADDR = {REG_MAX_POOL, 2'b00};
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    status_t                     st;
    logic [IDX_FIELD_BITS-1:0]   slot;
    logic [FREED_FIELD_BITS-1:0] freed;
  } slot_result_t;

  // DUT connections; the driven inputs are known from time zero
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       cmd = 1'b0;
  logic [KEY_FIELD_BITS-1:0]  tile_key = '0;
  logic                       busy;
  logic                       done;
  logic [1:0]                 status;
  logic [IDX_FIELD_BITS-1:0]  slot_index;
  logic [FREED_FIELD_BITS-1:0] freed_count;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0]   paddr = '0;
  logic [APB_DATA_BITS-1:0]   pwdata = '0;
  logic [APB_DATA_BITS-1:0]   prdata;
  logic                       pready;

  // Predictor state
  key_t   key_m [POOL_DEPTH];
  bit     mapped_m [POOL_DEPTH];
  bit     used_m [POOL_DEPTH];
  slot_t  free_stack_m [POOL_DEPTH];
  int     free_depth_m = 0;
  int     alloc_m = 0;
  int     max_pool_m = int'(MAX_POOL_RESET);

  // Expected results and bookkeeping
  slot_result_t pending_results[$];
  int mismatches = 0;
  int stall_cycles = 0;
  int idle_pct = 22;
  int n_words = 0, n_hit = 0, n_new = 0, n_full = 0, n_prune = 0, n_cfg = 0;

  keyed_slot_pool_with_use_aging dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .tile_key    (tile_key),
    .done        (done),
    .status      (status),
    .slot_index  (slot_index),
    .freed_count (freed_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Advance the pool predictor by one word and return its result
  function automatic slot_result_t predict_pool_step(input logic c, input key_t k);
    slot_result_t r;
    int  lim;
    int  idx;
    bit  hit;
    r.st    = ST_PRUNE;
    r.slot  = '0;
    r.freed = '0;
    if (c == CMD_PRUNE) begin
      // age out slots left unused since the last prune, in ascending order
      for (int i = 0; i < POOL_DEPTH; i++) begin
        if (mapped_m[i]) begin
          if (!used_m[i]) begin
            mapped_m[i] = 1'b0;
            if (free_depth_m < POOL_DEPTH) begin
              free_stack_m[free_depth_m] = slot_t'(i);
              free_depth_m++;
            end
            r.freed++;
          end else begin
            used_m[i] = 1'b0;
          end
        end
      end
    end else begin
      hit = 1'b0;
      idx = 0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        if (!hit && mapped_m[i] && key_m[i] == k) begin
          hit = 1'b1;
          idx = i;
        end
      end
      if (hit) begin
        used_m[idx] = 1'b1;
        r.st   = ST_HIT;
        r.slot = IDX_FIELD_BITS'(idx);
      end else begin
        lim = (max_pool_m > POOL_DEPTH) ? POOL_DEPTH : max_pool_m;
        // mint a fresh slot only when the free list is empty
        if (free_depth_m == 0 && alloc_m < lim) begin
          free_stack_m[0] = slot_t'(alloc_m);
          free_depth_m = 1;
          alloc_m++;
        end
        if (free_depth_m == 0) begin
          r.st = ST_FULL;
        end else begin
          free_depth_m--;
          idx = int'(free_stack_m[free_depth_m]);
          mapped_m[idx] = 1'b1;
          used_m[idx]   = 1'b1;
          key_m[idx]    = k;
          r.st   = ST_NEW;
          r.slot = IDX_FIELD_BITS'(idx);
        end
      end
    end
    return r;
  endfunction

  // Check result strobes, predict accepted words, track forward progress
  always @(posedge clk) begin : result_monitor
    slot_result_t want;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (done) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: status %0d slot %0d freed %0d",
                                    status, slot_index, freed_count));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st)
            report_mismatch($sformatf("status got %0d want %s", status, want.st.name()));
          if (slot_index !== want.slot)
            report_mismatch($sformatf("slot_index got %0d want %0d", slot_index, want.slot));
          if (freed_count !== want.freed)
            report_mismatch($sformatf("freed_count got %0d want %0d", freed_count, want.freed));
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        want = predict_pool_step(cmd, tile_key);
        pending_results.push_back(want);
        n_words++;
        case (want.st)
          ST_HIT:  n_hit++;
          ST_NEW:  n_new++;
          ST_FULL: n_full++;
          default: n_prune++;
        endcase
      end
      if (psel && penable && pready)
        moved = 1'b1;
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("keyed_slot_pool_with_use_aging regression: fail");
    $finish;
  end

  // Offer one word, idling at random first, and hold it until taken
  task automatic send_word(input logic c, input key_t k);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    cmd      <= c;
    tile_key <= k;
    do @(posedge clk); while (busy);
  endtask

  // Hold off new words until every expected result has come back
  task automatic settle_pool();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
  endtask

  task automatic apb_transfer(input bit wr, input logic [APB_DATA_BITS-1:0] wd,
                              output logic [APB_DATA_BITS-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAX_POOL_ADDR;
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program max_pool_size while idle, then read it back
  task automatic write_max_pool(input int v);
    logic [APB_DATA_BITS-1:0] wd;
    logic [APB_DATA_BITS-1:0] rd;
    wd = ($urandom() & ~32'h7f) | (v & 32'h7f);
    settle_pool();
    apb_transfer(1'b1, wd, rd);
    max_pool_m = v & 32'h7f;
    n_cfg++;
    apb_transfer(1'b0, '0, rd);
    if (rd !== APB_DATA_BITS'(max_pool_m))
      report_mismatch($sformatf("max_pool_size read %0h want %0h", rd, max_pool_m));
  endtask

  task automatic test_register_reset();
    logic [APB_DATA_BITS-1:0] rd;
    settle_pool();
    apb_transfer(1'b0, '0, rd);
    if (rd !== APB_DATA_BITS'(MAX_POOL_RESET))
      report_mismatch($sformatf("max_pool_size after reset %0h", rd));
  endtask

  task automatic test_fetch_and_full();
    // zero limit: nothing can be allocated
    write_max_pool(0);
    send_word(CMD_FETCH, 32'h0000_0000);
    // two slots, extreme keys, a hit and an overflow
    write_max_pool(2);
    send_word(CMD_FETCH, 32'h0000_0000);
    send_word(CMD_FETCH, 32'hffff_ffff);
    send_word(CMD_FETCH, 32'h0000_0000);
    send_word(CMD_FETCH, 32'h0000_0001);
  endtask

  task automatic test_prune_aging();
    send_word(CMD_PRUNE, 32'h0000_0000);
    send_word(CMD_FETCH, 32'hffff_ffff);
    send_word(CMD_PRUNE, 32'hffff_ffff);
    send_word(CMD_FETCH, 32'h5a5a_5a5a);
    send_word(CMD_PRUNE, 32'h1234_5678);
    send_word(CMD_PRUNE, 32'h0000_0000);
    // free list is LIFO: last pushed comes out first
    send_word(CMD_FETCH, 32'ha5a5_a5a5);
    send_word(CMD_FETCH, 32'h8000_0000);
  endtask

  task automatic test_limit_edges();
    // limit below the allocation: old slots recycle, no new ones
    write_max_pool(1);
    send_word(CMD_PRUNE, 32'h0);
    send_word(CMD_PRUNE, 32'h0);
    send_word(CMD_FETCH, 32'h0000_00aa);
    send_word(CMD_FETCH, 32'h0000_00bb);
    send_word(CMD_FETCH, 32'h0000_00cc);
    // limit above the pool acts as the pool depth
    write_max_pool(127);
    send_word(CMD_FETCH, 32'h7fff_ffff);
    write_max_pool(64);
    send_word(CMD_FETCH, 32'hdead_beef);
  endtask

  task automatic test_random_traffic();
    key_t keyset [96];
    key_t key;
    int   lim, nkeys, prune_pct, pick;
    foreach (keyset[i]) keyset[i] = $urandom();
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 8)
        0:       lim = 0;
        1:       lim = 1;
        2:       lim = POOL_DEPTH;
        3:       lim = $urandom_range(127, POOL_DEPTH + 1);
        4:       lim = $urandom_range(8, 2);
        default: lim = $urandom_range(127, 0);
      endcase
      write_max_pool(lim);
      idle_pct = (ph == 5) ? 0 : 22;
      // keep part of the key set so hits carry across phases
      foreach (keyset[i]) if ($urandom_range(1) == 0) keyset[i] = $urandom();
      nkeys = $urandom_range(96, 4);
      prune_pct = $urandom_range(15, 3);
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(99) < prune_pct) begin
          send_word(CMD_PRUNE, $urandom());
        end else begin
          pick = $urandom_range(99);
          if (pick < 85)      key = keyset[$urandom_range(nkeys - 1)];
          else if (pick < 95) key = $urandom();
          else if (pick < 97) key = '0;
          else                key = '1;
          send_word(CMD_FETCH, key);
        end
      end
    end
    idle_pct = 22;
  endtask

  initial begin : main_sequence
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_fetch_and_full();
    test_prune_aging();
    test_limit_edges();
    test_random_traffic();
    settle_pool();
    // drain: allow a full prune walk for stray strobes
    repeat (POOL_DEPTH + 16) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d words: %0d hits, %0d slot grants, %0d pool-full, %0d prunes",
             n_words, n_hit, n_new, n_full, n_prune);
    $display("across %0d max_pool_size settings from 0 through above-pool values; %0d mismatches",
             n_cfg, mismatches);
    if (mismatches == 0) begin
      $display("keyed_slot_pool_with_use_aging regression: pass");
    end else begin
      $display("keyed_slot_pool_with_use_aging regression: fail");
    end
    $finish;
  end

endmodule
